// ===== rtl/go_back_n_sender_window_macros.svh =====
// assertion helpers used by gbn_datapath
`ifndef GO_BACK_N_SENDER_WINDOW_MACROS_SVH
`define GO_BACK_N_SENDER_WINDOW_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define GBN_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define GBN_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg
// Types and constants of the go-back-n sender window controller.
// ----------------------------------------------------------------------------
`default_nettype none

package gbn_pkg;

   localparam int SEQ_BITS_DEFAULT   = 16;
   localparam int WINDOW_MAX_DEFAULT = 7;

   localparam int MODE_W     = 2;
   localparam int ACK_W      = 16;
   localparam int KIND_W     = 3;
   localparam int SEQ_OUT_W  = 16;
   localparam int FLIGHT_W   = 3;
   localparam int TOTAL_W    = 32;
   localparam int WINDOW_W   = 3;
   localparam int TIMER_W    = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET  = 3'd3;
   localparam logic [TIMER_W-1:0]  TIMEOUT_RESET = 16'd1000;

   // event codes
   localparam logic [MODE_W-1:0] MODE_SEND = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ACK  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

   // result codes
   localparam logic [KIND_W-1:0] KIND_SENT    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REFUSED = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ACK_OK  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ACK_IGN = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RETX    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_IDLE    = 3'd5;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW_SIZE   = 4'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TIMEOUT_TICKS = 4'd1;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_SEND,
      CMD_REFUSE,
      CMD_ACK,
      CMD_ACK_IGN,
      CMD_TICK_CLEAR,
      CMD_TICK_COUNT,
      CMD_EXPIRE,
      CMD_RETX_STEP,
      CMD_IDLE
   } gbn_cmd_type;

   typedef struct packed {
      logic out_free;
      logic busy_zero;
      logic can_send;
      logic ack_match;
      logic expire;
      logic burst_one;
      logic step_last;
   } gbn_status_type;

endpackage

`default_nettype wire

// ===== rtl/gbn_if.sv =====
// ----------------------------------------------------------------------------
// gbn_if
// Valid/ready channels of the sender window: event, result and register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbn_req_if import gbn_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [ACK_W-1:0]  ack_number;

   modport source (output valid, mode, ack_number, input ready);
   modport sink   (input valid, mode, ack_number, output ready);
endinterface

interface gbn_rsp_if import gbn_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    kind;
   logic [SEQ_OUT_W-1:0] seq_number;
   logic [FLIGHT_W-1:0]  in_flight;
   logic [TOTAL_W-1:0]   retransmit_total;
   logic                 last;

   modport source (output valid, kind, seq_number, in_flight, retransmit_total, last,
                   input ready);
   modport sink   (input valid, kind, seq_number, in_flight, retransmit_total, last,
                   output ready);
endinterface

interface gbn_csr_if import gbn_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/gbn_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbn_ctrl
// Event decoder and retransmit burst sequencer of the sender window.
// ----------------------------------------------------------------------------
`default_nettype none

module gbn_ctrl import gbn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [MODE_W-1:0] req_mode,
   output logic              req_ready,
   input  gbn_status_type    status,
   output gbn_cmd_type       cmd
);

   typedef enum logic {
      ST_RUN,
      ST_RETX
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = CMD_NONE;
      req_ready = (state_ff == ST_RUN) && status.out_free;
      unique case (state_ff)
         ST_RUN: begin
            if (req_valid && req_ready) begin
               unique case (req_mode)
                  MODE_SEND: cmd = status.can_send ? CMD_SEND : CMD_REFUSE;
                  MODE_ACK:  cmd = status.ack_match ? CMD_ACK : CMD_ACK_IGN;
                  MODE_TICK: begin
                     priority if (status.busy_zero) begin
                        cmd = CMD_TICK_CLEAR;
                     end else if (status.expire) begin
                        cmd = CMD_EXPIRE;
                        // first beat is registered now, the rest follow one per cycle while the result register is free
                        if (!status.burst_one) begin
                           state_in = ST_RETX;
                        end
                     end else begin
                        cmd = CMD_TICK_COUNT;
                     end
                  end
                  default: cmd = CMD_IDLE;
               endcase
            end
         end
         ST_RETX: begin
            if (status.out_free) begin
               cmd = CMD_RETX_STEP;
               if (status.step_last) begin
                  state_in = ST_RUN;
               end
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/gbn_datapath.sv =====
// ----------------------------------------------------------------------------
// gbn_datapath
// Sequence, timer and retransmit counters, config registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "go_back_n_sender_window_macros.svh"

module gbn_datapath import gbn_pkg::*; #(
   parameter int SEQ_BITS   = SEQ_BITS_DEFAULT,
   parameter int WINDOW_MAX = WINDOW_MAX_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gbn_cmd_type           cmd,
   output gbn_status_type        status,
   input  logic [ACK_W-1:0]      req_ack_number,
   input  logic                  csr_valid,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [KIND_W-1:0]     rsp_kind,
   output logic [SEQ_OUT_W-1:0]  rsp_seq_number,
   output logic [FLIGHT_W-1:0]   rsp_in_flight,
   output logic [TOTAL_W-1:0]    rsp_retransmit_total,
   output logic                  rsp_last
);

   localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
   localparam int STEP_W = CNT_W + 1;
   localparam int CMP_W  = (SEQ_BITS > ACK_W) ? SEQ_BITS : ACK_W;
   localparam int EFF_W  = (CNT_W > WINDOW_W) ? CNT_W : WINDOW_W;

   logic [SEQ_BITS-1:0]  next_seq_ff, next_seq_in;
   logic [SEQ_BITS-1:0]  oldest_ff, oldest_in;
   logic [TIMER_W-1:0]   elapsed_ff, elapsed_in;
   logic [TOTAL_W-1:0]   retx_count_ff, retx_count_in;
   logic [CNT_W-1:0]     retx_idx_ff, retx_idx_in;
   logic [WINDOW_W-1:0]  window_size_ff;
   logic [TIMER_W-1:0]   timeout_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [SEQ_OUT_W-1:0] seq_ff, seq_in;
   logic [FLIGHT_W-1:0]  flight_ff, flight_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic                 last_ff, last_in;
   logic                 load;

   logic [SEQ_BITS-1:0]  busy_full;
   logic [CMP_W-1:0]     busy_cmp;
   logic [CNT_W-1:0]     busy_cnt;
   logic [FLIGHT_W-1:0]  busy_low;
   logic [EFF_W-1:0]     eff_window;
   logic [TIMER_W-1:0]   elapsed_inc;
   logic [TIMER_W-1:0]   limit;
   logic [SEQ_BITS-1:0]  step_seq;
   logic [CMP_W-1:0]     next_seq_wide;
   logic [CMP_W-1:0]     oldest_wide;
   logic [CMP_W-1:0]     step_seq_wide;

   always_comb begin
      busy_full   = next_seq_ff - oldest_ff;
      busy_cmp    = CMP_W'(busy_full);
      // outstanding count never exceeds the largest window
      busy_cnt    = busy_cmp[CNT_W-1:0];
      busy_low    = busy_full[FLIGHT_W-1:0];
      eff_window  = (EFF_W'(window_size_ff) > EFF_W'(WINDOW_MAX)) ?
                    EFF_W'(WINDOW_MAX) : EFF_W'(window_size_ff);
      elapsed_inc = elapsed_ff + TIMER_W'(1);
      limit       = (timeout_ff == '0) ? TIMER_W'(1) : timeout_ff;
      step_seq    = oldest_ff + SEQ_BITS'(retx_idx_ff) + SEQ_BITS'(1);
      next_seq_wide = CMP_W'(next_seq_ff);
      oldest_wide   = CMP_W'(oldest_ff);
      step_seq_wide = CMP_W'(step_seq);

      status.out_free  = !rsp_valid_ff || rsp_ready;
      status.busy_zero = (busy_full == '0);
      status.can_send  = busy_cmp < CMP_W'(eff_window);
      // ack numbers with bits above the sequence width never match
      status.ack_match = (busy_full != '0) && (CMP_W'(req_ack_number) == oldest_wide);
      status.expire    = elapsed_inc >= limit;
      status.burst_one = (busy_cnt == CNT_W'(1));
      status.step_last = (STEP_W'(retx_idx_ff) + STEP_W'(2)) == STEP_W'(busy_cnt);
   end

   always_comb begin
      next_seq_in   = next_seq_ff;
      oldest_in     = oldest_ff;
      elapsed_in    = elapsed_ff;
      retx_count_in = retx_count_ff;
      retx_idx_in   = retx_idx_ff;
      load          = 1'b1;
      kind_in       = KIND_IDLE;
      seq_in        = '0;
      flight_in     = busy_low;
      total_in      = retx_count_ff;
      last_in       = 1'b1;
      unique case (cmd)
         CMD_SEND: begin
            next_seq_in = next_seq_ff + SEQ_BITS'(1);
            if (status.busy_zero) begin
               elapsed_in = '0;
            end
            kind_in   = KIND_SENT;
            seq_in    = next_seq_wide[SEQ_OUT_W-1:0];
            flight_in = busy_low + FLIGHT_W'(1);
         end
         CMD_REFUSE:  kind_in = KIND_REFUSED;
         CMD_ACK: begin
            oldest_in  = oldest_ff + SEQ_BITS'(1);
            elapsed_in = '0;
            kind_in    = KIND_ACK_OK;
            seq_in     = req_ack_number;
            flight_in  = busy_low - FLIGHT_W'(1);
         end
         CMD_ACK_IGN: kind_in = KIND_ACK_IGN;
         CMD_TICK_CLEAR: begin
            elapsed_in = '0;
         end
         CMD_TICK_COUNT: begin
            elapsed_in = elapsed_inc;
         end
         CMD_EXPIRE: begin
            elapsed_in    = '0;
            retx_count_in = retx_count_ff + TOTAL_W'(1);
            retx_idx_in   = '0;
            kind_in       = KIND_RETX;
            seq_in        = oldest_wide[SEQ_OUT_W-1:0];
            total_in      = retx_count_ff + TOTAL_W'(1);
            last_in       = status.burst_one;
         end
         CMD_RETX_STEP: begin
            retx_count_in = retx_count_ff + TOTAL_W'(1);
            retx_idx_in   = retx_idx_ff + CNT_W'(1);
            kind_in       = KIND_RETX;
            seq_in        = step_seq_wide[SEQ_OUT_W-1:0];
            total_in      = retx_count_ff + TOTAL_W'(1);
            last_in       = status.step_last;
         end
         CMD_IDLE: kind_in = KIND_IDLE;
         default:  load = 1'b0;
      endcase
      rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_seq_ff    <= '0;
         oldest_ff      <= '0;
         elapsed_ff     <= '0;
         retx_count_ff  <= '0;
         retx_idx_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         window_size_ff <= WINDOW_RESET;
         timeout_ff     <= TIMEOUT_RESET;
      end else begin
         next_seq_ff   <= next_seq_in;
         oldest_ff     <= oldest_in;
         elapsed_ff    <= elapsed_in;
         retx_count_ff <= retx_count_in;
         retx_idx_ff   <= retx_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && (csr_index == CSR_WINDOW_SIZE)) begin
            window_size_ff <= csr_data[WINDOW_W-1:0];
         end
         if (csr_valid && (csr_index == CSR_TIMEOUT_TICKS)) begin
            timeout_ff <= csr_data[TIMER_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff   <= kind_in;
         seq_ff    <= seq_in;
         flight_ff <= flight_in;
         total_ff  <= total_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_kind             = kind_ff;
   assign rsp_seq_number       = seq_ff;
   assign rsp_in_flight        = flight_ff;
   assign rsp_retransmit_total = total_ff;
   assign rsp_last             = last_ff;

   `GBN_ASSERT_IMP(a_window_bound, clock, reset, 1'b1, busy_cmp <= CMP_W'(WINDOW_MAX), "outstanding count above window")
   `GBN_ASSERT_IMP(a_step_in_range, clock, reset, cmd == CMD_RETX_STEP, (STEP_W'(retx_idx_ff) + STEP_W'(1)) < STEP_W'(busy_cnt), "retransmit step past outstanding range")
   `GBN_ASSERT_NXT(a_send_advances, clock, reset, cmd == CMD_SEND, next_seq_ff == $past(next_seq_ff) + SEQ_BITS'(1), "send did not advance sequence")
   `GBN_ASSERT_NXT(a_retx_counts, clock, reset, (cmd == CMD_EXPIRE) || (cmd == CMD_RETX_STEP), retx_count_ff == $past(retx_count_ff) + TOTAL_W'(1), "retransmit beat not counted")

endmodule

`default_nettype wire

// ===== rtl/go_back_n_sender_window.sv =====
// ----------------------------------------------------------------------------
// go_back_n_sender_window
// Sequence and timeout controller of a go-back-n sender.
// ----------------------------------------------------------------------------
// Each beat on req_ch is one event: send request, received ack or timer tick.
// Each event produces result beats on rsp_ch; the final one has last set.
// Sends, acks, ticks that do not expire and unused event codes give one beat,
// registered in the cycle after the event is taken; one event per cycle is
// taken while the result register drains.
// An expiring tick gives one retransmit beat per outstanding packet, oldest
// first, one per cycle while the receiver takes them: the burst sequencer
// holds req_ch.ready low after the tick until the last beat is loaded.
// When the receiver stalls, the result register holds its beat and ready on
// req_ch drops until the beat is taken.
// csr_ch writes window_size (index 0) and timeout_ticks (index 1); it is
// always ready and should be written only while the block is idle.
// Synchronous reset clears the counters and the result valid flag and restores
// window_size 3 and timeout_ticks 1000; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module go_back_n_sender_window import gbn_pkg::*; #(
   parameter int SEQ_BITS   = SEQ_BITS_DEFAULT,
   parameter int WINDOW_MAX = WINDOW_MAX_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   gbn_req_if.sink   req_ch,
   gbn_rsp_if.source rsp_ch,
   gbn_csr_if.sink   csr_ch
);

   gbn_cmd_type    cmd;
   gbn_status_type status;

   assign csr_ch.ready = 1'b1;

   gbn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_mode  (req_ch.mode),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   gbn_datapath #(
      .SEQ_BITS   (SEQ_BITS),
      .WINDOW_MAX (WINDOW_MAX)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_ack_number       (req_ch.ack_number),
      .csr_valid            (csr_ch.valid),
      .csr_index            (csr_ch.index),
      .csr_data             (csr_ch.data),
      .rsp_ready            (rsp_ch.ready),
      .rsp_valid            (rsp_ch.valid),
      .rsp_kind             (rsp_ch.kind),
      .rsp_seq_number       (rsp_ch.seq_number),
      .rsp_in_flight        (rsp_ch.in_flight),
      .rsp_retransmit_total (rsp_ch.retransmit_total),
      .rsp_last             (rsp_ch.last)
   );

endmodule

`default_nettype wire
